// ===== design/cau_pkg.sv =====
// shared definitions for the complex accumulator alu
// action codes, product select codes and controller/datapath interface structs
// no dependencies
`default_nettype none

package cau_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int DATA_W        = 32;
  localparam int ACT_W         = 3;
  localparam int SEL_W         = 3;

  // action codes
  localparam logic [ACT_W-1:0] ACT_LOAD = 3'd0;
  localparam logic [ACT_W-1:0] ACT_ADD  = 3'd1;
  localparam logic [ACT_W-1:0] ACT_SUB  = 3'd2;
  localparam logic [ACT_W-1:0] ACT_MUL  = 3'd3;
  localparam logic [ACT_W-1:0] ACT_DIV  = 3'd4;

  // product select codes, issued in this order
  localparam logic [SEL_W-1:0] SEL_AR_BR = 3'd0;
  localparam logic [SEL_W-1:0] SEL_AI_BI = 3'd1;
  localparam logic [SEL_W-1:0] SEL_AR_BI = 3'd2;
  localparam logic [SEL_W-1:0] SEL_AI_BR = 3'd3;
  localparam logic [SEL_W-1:0] SEL_BR_BR = 3'd4;
  localparam logic [SEL_W-1:0] SEL_BI_BI = 3'd5;

  localparam logic [SEL_W-1:0] NPROD_MUL = 3'd4;
  localparam logic [SEL_W-1:0] NPROD_DIV = 3'd6;

  typedef struct packed {
    logic             capture;
    logic             mul_en;
    logic [SEL_W-1:0] mul_sel;
    logic             div_init;
    logic             div_step;
    logic             commit;
  } cmd_t;

  typedef struct packed {
    logic den_zero;
  } sts_t;

endpackage

`default_nettype wire

// ===== design/cau_ctrl.sv =====
// controller state machine for the complex accumulator alu
// sequences products and divide steps; uses cau_pkg
`default_nettype none

module cau_ctrl #(
  parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [cau_pkg::ACT_W-1:0]  action,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output cau_pkg::cmd_t                   cmd,
  input  wire cau_pkg::sts_t              sts
);

  localparam int DIV_STEPS = 64 + FRAC_BITS;
  localparam int DCW       = $clog2(DIV_STEPS);
  localparam logic [DCW-1:0] DIV_LAST = DCW'(DIV_STEPS - 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_MUL    = 3'd1;
  localparam logic [2:0] S_DIVINI = 3'd2;
  localparam logic [2:0] S_DIV    = 3'd3;
  localparam logic [2:0] S_COMMIT = 3'd4;

  logic [2:0]                state, state_next;
  logic [cau_pkg::ACT_W-1:0] act, act_next;
  logic [cau_pkg::SEL_W-1:0] pcnt, pcnt_next;
  logic [DCW-1:0]            dcnt, dcnt_next;
  logic                      out_valid_next;
  logic                      out_free;
  logic [cau_pkg::SEL_W-1:0] nprod;

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;
  assign nprod    = (act == cau_pkg::ACT_DIV) ? cau_pkg::NPROD_DIV : cau_pkg::NPROD_MUL;

  always_comb begin
    state_next     = state;
    act_next       = act;
    pcnt_next      = pcnt;
    dcnt_next      = dcnt;
    out_valid_next = out_valid && out_stall;
    cmd            = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          act_next    = action;
          pcnt_next   = '0;
          if (action == cau_pkg::ACT_MUL || action == cau_pkg::ACT_DIV) begin
            state_next = S_MUL;
          end else begin
            state_next = S_COMMIT;
          end
        end
      end
      S_MUL: begin
        if (pcnt < nprod) begin
          cmd.mul_en  = 1'b1;
          cmd.mul_sel = pcnt;
          pcnt_next   = pcnt + 1'b1;
        end else if (act == cau_pkg::ACT_DIV) begin
          state_next = S_DIVINI;
        end else begin
          state_next = S_COMMIT;
        end
      end
      S_DIVINI: begin
        dcnt_next = '0;
        if (sts.den_zero) begin
          state_next = S_COMMIT;
        end else begin
          cmd.div_init = 1'b1;
          state_next   = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        dcnt_next    = dcnt + 1'b1;
        if (dcnt == DIV_LAST) begin
          state_next = S_COMMIT;
        end
      end
      S_COMMIT: begin
        if (out_free) begin
          cmd.commit     = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
    act  <= act_next;
    pcnt <= pcnt_next;
    dcnt <= dcnt_next;
  end

`ifndef SYNTHESIS
  a_commit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> (!out_valid || !out_stall))
    else $error("commit while result slot busy");
  a_rose_commit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.commit))
    else $error("result shown without commit");
  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    cmd.div_step |-> !sts.den_zero)
    else $error("divide step with zero denominator");
  a_div_cnt: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (dcnt <= DIV_LAST))
    else $error("divide counter out of range");
`endif

endmodule

`default_nettype wire

// ===== design/cau_dp.sv =====
// datapath for the complex accumulator alu
// accumulator, shared multiplier, two bit-serial dividers, saturation; uses cau_pkg
`default_nettype none

module cau_dp #(
  parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic [cau_pkg::ACT_W-1:0]  action,
  input  wire logic signed [31:0]         operand_real,
  input  wire logic signed [31:0]         operand_imag,
  output logic signed [31:0]              result_real,
  output logic signed [31:0]              result_imag,
  output logic                            overflow,
  output logic                            divide_by_zero,
  input  wire cau_pkg::cmd_t              cmd,
  output cau_pkg::sts_t                   sts
);

  logic signed [31:0]        acc_r, acc_i, op_r, op_i, ma, mb;
  logic [cau_pkg::ACT_W-1:0] act;
  logic signed [63:0]        prod;
  logic [cau_pkg::SEL_W-1:0] ptag;
  logic                      pvld;
  logic signed [65:0]        sum_r, sum_i, pext, neg_r, neg_i;
  logic [63:0]               den;
  logic                      is_div;

  // divider lanes: 0 real, 1 imaginary
  logic [63:0] dvd [2];
  logic [63:0] rem [2];
  logic [32:0] quo [2];
  logic        big [2];
  logic        sgn [2];

  assign is_div       = (act == cau_pkg::ACT_DIV);
  assign pext         = 66'(prod);
  assign sts.den_zero = (den == 64'd0);
  assign neg_r        = -sum_r;
  assign neg_i        = -sum_i;

  always_comb begin
    case (cmd.mul_sel)
      cau_pkg::SEL_AR_BR: begin ma = acc_r; mb = op_r; end
      cau_pkg::SEL_AI_BI: begin ma = acc_i; mb = op_i; end
      cau_pkg::SEL_AR_BI: begin ma = acc_r; mb = op_i; end
      cau_pkg::SEL_AI_BR: begin ma = acc_i; mb = op_r; end
      cau_pkg::SEL_BR_BR: begin ma = op_r;  mb = op_r; end
      cau_pkg::SEL_BI_BI: begin ma = op_i;  mb = op_i; end
      default:            begin ma = op_r;  mb = op_r; end
    endcase
  end

  // {ovf, value} for a wide signed value
  function automatic logic [32:0] sat66(input logic signed [65:0] v);
    logic [34:0] hi;
    hi = v[65:31];
    if (&hi || ~|hi) begin
      sat66 = {1'b0, v[31:0]};
    end else if (v[65]) begin
      sat66 = {1'b1, 32'h8000_0000};
    end else begin
      sat66 = {1'b1, 32'h7fff_ffff};
    end
  endfunction

  // {ovf, value} from a divider lane, floor rounding
  function automatic logic [32:0] div_fix(input logic neg, input logic [32:0] q,
                                          input logic bg, input logic inexact);
    logic [33:0] m;
    m = {1'b0, q} + {33'd0, inexact};
    if (!neg) begin
      if (bg || q[32] || q[31]) begin
        div_fix = {1'b1, 32'h7fff_ffff};
      end else begin
        div_fix = {1'b0, q[31:0]};
      end
    end else if (bg || m > 34'h0_8000_0000) begin
      div_fix = {1'b1, 32'h8000_0000};
    end else begin
      div_fix = {1'b0, 32'd0 - m[31:0]};
    end
  endfunction

  logic signed [32:0] add_r, add_i, sub_r, sub_i;
  logic [32:0]        fr, fi;
  logic [64:0]        trial [2];

  assign add_r = 33'(acc_r) + 33'(op_r);
  assign add_i = 33'(acc_i) + 33'(op_i);
  assign sub_r = 33'(acc_r) - 33'(op_r);
  assign sub_i = 33'(acc_i) - 33'(op_i);

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      trial[l] = {rem[l], dvd[l][63]};
    end
  end

  always_comb begin
    fr = {1'b0, acc_r};
    fi = {1'b0, acc_i};
    case (act)
      cau_pkg::ACT_LOAD: begin fr = {1'b0, op_r}; fi = {1'b0, op_i}; end
      cau_pkg::ACT_ADD:  begin fr = sat66(66'(add_r)); fi = sat66(66'(add_i)); end
      cau_pkg::ACT_SUB:  begin fr = sat66(66'(sub_r)); fi = sat66(66'(sub_i)); end
      cau_pkg::ACT_MUL: begin
        fr = sat66(sum_r >>> FRAC_BITS);
        fi = sat66(sum_i >>> FRAC_BITS);
      end
      cau_pkg::ACT_DIV: begin
        if (!sts.den_zero) begin
          fr = div_fix(sgn[0], quo[0], big[0], rem[0] != 64'd0);
          fi = div_fix(sgn[1], quo[1], big[1], rem[1] != 64'd0);
        end
      end
      default: begin
        fr = {1'b0, acc_r};
        fi = {1'b0, acc_i};
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_r <= '0;
      acc_i <= '0;
    end else if (cmd.commit) begin
      acc_r <= fr[31:0];
      acc_i <= fi[31:0];
    end
    if (cmd.commit) begin
      overflow       <= fr[32] | fi[32];
      divide_by_zero <= is_div && sts.den_zero;
    end
    if (cmd.capture) begin
      act   <= action;
      op_r  <= operand_real;
      op_i  <= operand_imag;
      sum_r <= '0;
      sum_i <= '0;
      den   <= '0;
    end else if (pvld) begin
      case (ptag)
        cau_pkg::SEL_AR_BR: sum_r <= sum_r + pext;
        cau_pkg::SEL_AI_BI: sum_r <= is_div ? sum_r + pext : sum_r - pext;
        cau_pkg::SEL_AR_BI: sum_i <= is_div ? sum_i - pext : sum_i + pext;
        cau_pkg::SEL_AI_BR: sum_i <= sum_i + pext;
        default:            den   <= den + prod[63:0];
      endcase
    end
    pvld <= cmd.mul_en && !cmd.capture;
    ptag <= cmd.mul_sel;
    if (cmd.mul_en) begin
      prod <= ma * mb;
    end
    if (cmd.div_init) begin
      sgn[0] <= sum_r[65];
      sgn[1] <= sum_i[65];
      dvd[0] <= sum_r[65] ? neg_r[63:0] : sum_r[63:0];
      dvd[1] <= sum_i[65] ? neg_i[63:0] : sum_i[63:0];
      for (int l = 0; l < 2; l++) begin
        rem[l] <= '0;
        quo[l] <= '0;
        big[l] <= 1'b0;
      end
    end else if (cmd.div_step) begin
      for (int l = 0; l < 2; l++) begin
        dvd[l] <= {dvd[l][62:0], 1'b0};
        big[l] <= big[l] | quo[l][32];
        if (trial[l] >= {1'b0, den}) begin
          rem[l] <= 64'(trial[l] - {1'b0, den});
          quo[l] <= {quo[l][31:0], 1'b1};
        end else begin
          rem[l] <= trial[l][63:0];
          quo[l] <= {quo[l][31:0], 1'b0};
        end
      end
    end
  end

  assign result_real = acc_r;
  assign result_imag = acc_i;

endmodule

`default_nettype wire

// ===== design/complex_accumulator_alu_unit.sv =====
// top level of the complex accumulator alu
// joins cau_ctrl and cau_dp; uses cau_pkg
//
//  channel | valid     | stall     | payload
//  input   | in_valid  | in_stall  | action, operand_real, operand_imag
//  output  | out_valid | out_stall | result_real, result_imag, overflow, divide_by_zero
//
// load, add, subtract and unknown actions go straight from capture to commit
// multiply: 4 products through one shared 32x32 multiplier plus drain
// divide: products, then unless the denominator is zero the bit-serial restoring divider
//   (64 + FRAC_BITS steps, real and imaginary lanes in parallel)
// reset clears the accumulator to zero and empties the output register
// a new item is taken while a result waits; commit holds until the output slot frees
`default_nettype none

module complex_accumulator_alu_unit #(
  parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic [cau_pkg::ACT_W-1:0] action,
  input  wire logic signed [31:0]        operand_real,
  input  wire logic signed [31:0]        operand_imag,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic signed [31:0]             result_real,
  output logic signed [31:0]             result_imag,
  output logic                           overflow,
  output logic                           divide_by_zero
);

  // command and status between sequencer and datapath
  cau_pkg::cmd_t cmd;
  cau_pkg::sts_t sts;

  cau_ctrl #(.FRAC_BITS(FRAC_BITS)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .action    (action),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  // accumulator doubles as the result register: it only changes on commit or reset
  cau_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
    .clk            (clk),
    .rst            (rst),
    .action         (action),
    .operand_real   (operand_real),
    .operand_imag   (operand_imag),
    .result_real    (result_real),
    .result_imag    (result_imag),
    .overflow       (overflow),
    .divide_by_zero (divide_by_zero),
    .cmd            (cmd),
    .sts            (sts)
  );

endmodule

`default_nettype wire

// ===== sim/complex_accumulator_alu_checker.sv =====
// result checker for the complex accumulator alu testbench
// watches both channels, predicts each result and compares; uses cau_pkg
`default_nettype none

module complex_accumulator_alu_checker #(
  parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  input  wire logic                      in_stall,
  input  wire logic [cau_pkg::ACT_W-1:0] action,
  input  wire logic signed [31:0]        operand_real,
  input  wire logic signed [31:0]        operand_imag,
  input  wire logic                      out_valid,
  input  wire logic                      out_stall,
  input  wire logic signed [31:0]        result_real,
  input  wire logic signed [31:0]        result_imag,
  input  wire logic                      overflow,
  input  wire logic                      divide_by_zero,
  output int                             errors,
  output int                             pending
);

  typedef struct packed {
    logic [31:0] re;
    logic [31:0] im;
    logic        ovf;
    logic        dz;
  } acc_result_t;

  localparam logic signed [127:0] PART_MAX = 128'sd2147483647;
  localparam logic signed [127:0] PART_MIN = -128'sd2147483648;

  acc_result_t      acc_results_q[$];
  logic signed [31:0] acc_re, acc_im;

  function automatic logic [31:0] clamp_part(input logic signed [127:0] v, inout logic ovf);
    if (v > PART_MAX) begin
      ovf = 1'b1;
      return 32'h7FFF_FFFF;
    end
    if (v < PART_MIN) begin
      ovf = 1'b1;
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

  // floor of num * 2^FRAC_BITS / den
  function automatic logic signed [127:0] floor_quot(input logic signed [127:0] num,
                                                     input logic [127:0] den);
    logic [127:0] mag, q, r;
    mag = (num < 0) ? -num : num;
    q = (mag << FRAC_BITS) / den;
    r = (mag << FRAC_BITS) % den;
    if (num < 0) return -$signed(q + (r != 0));
    return $signed(q);
  endfunction

  function automatic acc_result_t next_acc(input logic [cau_pkg::ACT_W-1:0] act,
                                           input logic signed [31:0] br32,
                                           input logic signed [31:0] bi32);
    acc_result_t res;
    logic signed [127:0] ar, ai, br, bi, den;
    logic o;
    ar = acc_re;
    ai = acc_im;
    br = br32;
    bi = bi32;
    o = 1'b0;
    res.re = acc_re;
    res.im = acc_im;
    res.dz = 1'b0;
    case (act)
      cau_pkg::ACT_LOAD: begin
        res.re = br32;
        res.im = bi32;
      end
      cau_pkg::ACT_ADD: begin
        res.re = clamp_part(ar + br, o);
        res.im = clamp_part(ai + bi, o);
      end
      cau_pkg::ACT_SUB: begin
        res.re = clamp_part(ar - br, o);
        res.im = clamp_part(ai - bi, o);
      end
      cau_pkg::ACT_MUL: begin
        res.re = clamp_part((ar * br - ai * bi) >>> FRAC_BITS, o);
        res.im = clamp_part((ar * bi + ai * br) >>> FRAC_BITS, o);
      end
      cau_pkg::ACT_DIV: begin
        den = br * br + bi * bi;
        if (den == 0) begin
          res.dz = 1'b1;
        end else begin
          res.re = clamp_part(floor_quot(ar * br + ai * bi, den), o);
          res.im = clamp_part(floor_quot(ai * br - ar * bi, den), o);
        end
      end
      default: ;  // unknown action keeps the accumulator
    endcase
    res.ovf = o;
    return res;
  endfunction

  assign pending = acc_results_q.size();

  always @(posedge clk) begin
    acc_result_t want;
    if (rst) begin
      acc_re <= '0;
      acc_im <= '0;
      errors <= 0;
      acc_results_q.delete();
    end else begin
      if (in_valid && !in_stall) begin
        want = next_acc(action, operand_real, operand_imag);
        acc_results_q.push_back(want);
        acc_re <= want.re;
        acc_im <= want.im;
      end
      if (out_valid && !out_stall) begin
        if (acc_results_q.size() == 0) begin
          $display("%0t: unexpected result transfer re=%h im=%h", $time,
                   result_real, result_imag);
          errors <= errors + 1;
        end else begin
          want = acc_results_q.pop_front();
          if (want.re !== result_real || want.im !== result_imag ||
              want.ovf !== overflow || want.dz !== divide_by_zero) begin
            $display("%0t: mismatch exp %h %h ovf=%b dz=%b got %h %h ovf=%b dz=%b",
                     $time, want.re, want.im, want.ovf, want.dz,
                     result_real, result_imag, overflow, divide_by_zero);
            errors <= errors + 1;
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== sim/complex_accumulator_alu_unit_tb.sv =====
// testbench top for complex_accumulator_alu_unit
// drives stimulus and decides the verdict; needs cau_pkg, the dut and complex_accumulator_alu_checker
`default_nettype none

module complex_accumulator_alu_unit_tb;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int RANDOM_ITEMS   = 500;
  localparam int LONG_HOLD      = 400;
  localparam logic [cau_pkg::ACT_W-1:0] ACT_UNK_A = 3'd5;
  localparam logic [cau_pkg::ACT_W-1:0] ACT_UNK_B = 3'd6;
  localparam logic [cau_pkg::ACT_W-1:0] ACT_UNK_C = 3'd7;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [cau_pkg::ACT_W-1:0] action = cau_pkg::ACT_LOAD;
  logic signed [31:0] operand_real = '0;
  logic signed [31:0] operand_imag = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] result_real, result_imag;
  logic overflow, divide_by_zero;
  int errors, pending;

  // sender and receiver controls
  bit quiet = 1'b0;      // no idling in the final stretch
  bit hold_now = 1'b0;   // request one long receiver hold-off
  int idle_cycles = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  complex_accumulator_alu_unit uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .action(action), .operand_real(operand_real), .operand_imag(operand_imag),
    .out_valid(out_valid), .out_stall(out_stall),
    .result_real(result_real), .result_imag(result_imag),
    .overflow(overflow), .divide_by_zero(divide_by_zero)
  );

  complex_accumulator_alu_checker chk (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .action(action), .operand_real(operand_real), .operand_imag(operand_imag),
    .out_valid(out_valid), .out_stall(out_stall),
    .result_real(result_real), .result_imag(result_imag),
    .overflow(overflow), .divide_by_zero(divide_by_zero),
    .errors(errors), .pending(pending)
  );

  // watchdog: cycles with no transfer on either channel
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // receiver: random stall bursts plus one long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_now) begin
        out_stall = 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
        hold_now = 1'b0;
        out_stall = 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        out_stall = 1'b1;
        repeat ($urandom_range(1, 19) - 1) @(negedge clk);
      end else begin
        out_stall = 1'b0;
      end
    end
  end

  // one transfer on the input channel; valid stays high into the next item
  task automatic send(input logic [cau_pkg::ACT_W-1:0] act, input logic [31:0] re,
                      input logic [31:0] im);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    in_valid = 1'b1;
    action = act;
    operand_real = re;
    operand_imag = im;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // operand part: mostly moderate values, some full width and some extremes
  function automatic logic [31:0] rand_part();
    case ($urandom_range(0, 9))
      0, 1:    return $urandom();
      2:       return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      3:       return 32'($signed($urandom_range(0, 8)) - 4);
      4, 5:    return 32'($signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000);
      default: return 32'($signed($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000);
    endcase
  endfunction

  function automatic logic [cau_pkg::ACT_W-1:0] rand_action();
    int p;
    p = $urandom_range(0, 99);
    if (p < 15) return cau_pkg::ACT_LOAD;
    if (p < 32) return cau_pkg::ACT_ADD;
    if (p < 49) return cau_pkg::ACT_SUB;
    if (p < 71) return cau_pkg::ACT_MUL;
    if (p < 95) return cau_pkg::ACT_DIV;
    return cau_pkg::ACT_W'($urandom_range(ACT_UNK_A, ACT_UNK_C));
  endfunction

  initial begin
    logic [cau_pkg::ACT_W-1:0] act;
    int t;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: extremes, every action, saturation, zero denominator, unknown actions
    send(cau_pkg::ACT_ADD, 32'h0001_0000, 32'hFFFF_0000);   // add onto reset value
    send(cau_pkg::ACT_LOAD, 32'h7FFF_FFFF, 32'h8000_0000);
    send(cau_pkg::ACT_ADD, 32'h0000_0001, 32'hFFFF_FFFF);   // both parts saturate
    send(cau_pkg::ACT_SUB, 32'hFFFF_FFFF, 32'h0000_0001);   // both parts saturate through subtract
    send(cau_pkg::ACT_MUL, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send(cau_pkg::ACT_LOAD, 32'h0002_0000, 32'h0003_0000);
    send(cau_pkg::ACT_MUL, 32'h0001_8000, 32'hFFFF_0000);
    send(cau_pkg::ACT_MUL, 32'h0000_0001, 32'h0000_0000);   // scale down by one lsb; floor drops the fraction
    send(cau_pkg::ACT_LOAD, 32'hFFFF_FFFF, 32'h0000_0001);
    send(cau_pkg::ACT_MUL, 32'h0000_0003, 32'h0000_0000);
    send(cau_pkg::ACT_LOAD, 32'h0005_0000, 32'hFFFD_0000);
    send(cau_pkg::ACT_DIV, 32'h0000_0000, 32'h0000_0000);   // zero denominator
    send(cau_pkg::ACT_DIV, 32'h0001_0000, 32'h0002_0000);
    send(cau_pkg::ACT_DIV, 32'h0000_0003, 32'h0000_0000);   // quotient too large
    send(cau_pkg::ACT_DIV, 32'h8000_0000, 32'h8000_0000);
    send(cau_pkg::ACT_DIV, 32'h7FFF_FFFF, 32'h0000_0001);
    send(cau_pkg::ACT_LOAD, 32'h8000_0000, 32'h7FFF_FFFF);
    send(cau_pkg::ACT_DIV, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send(ACT_UNK_A, 32'h1234_5678, 32'h9ABC_DEF0);
    send(ACT_UNK_B, 32'hFFFF_FFFF, 32'h0000_0000);
    send(ACT_UNK_C, 32'h0000_0000, 32'hFFFF_FFFF);
    send(cau_pkg::ACT_MUL, 32'h8000_0000, 32'h0000_0000);
    send(cau_pkg::ACT_SUB, 32'h8000_0000, 32'h8000_0000);

    for (t = 0; t < RANDOM_ITEMS; t++) begin
      // long receiver hold-off while items keep coming
      if (t == 100) hold_now = 1'b1;
      // sender drains the block once before continuing
      if (t == 250) begin
        in_valid = 1'b0;
        while (pending != 0) @(negedge clk);
      end
      if (t == RANDOM_ITEMS - 80) quiet = 1'b1;
      // reload now and then so the accumulator does not sit at a rail
      act = ($urandom_range(0, 7) == 0) ? cau_pkg::ACT_LOAD : rand_action();
      if ($urandom_range(0, 29) == 0) send(cau_pkg::ACT_DIV, 32'h0, 32'h0);
      else send(act, rand_part(), rand_part());
    end
    in_valid = 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (120) @(negedge clk);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
design/cau_pkg.sv
design/cau_ctrl.sv
design/cau_dp.sv
design/complex_accumulator_alu_unit.sv
sim/complex_accumulator_alu_checker.sv
sim/complex_accumulator_alu_unit_tb.sv
